// ----- design/llq_pkg.sv -----
package llq_pkg;

	localparam int NODES   = 16;
	localparam int QUEUES  = 4;
	localparam int NODE_W  = $clog2(NODES);
	localparam int QUEUE_W = $clog2(QUEUES);
	localparam int COUNT_W = $clog2(NODES + 1);

	typedef enum logic {
		FUNC_APPEND = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK             = 2'd0,
		ST_ALREADY_QUEUED = 2'd1,
		ST_QUEUE_EMPTY    = 2'd2,
		ST_NOT_IN_QUEUE   = 2'd3
	} status_t;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [QUEUE_W-1:0] queue_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		func_t  func;
		queue_t queue_id;
		node_t  node_index;
	} req_t;

	typedef struct packed {
		status_t status;
		count_t  count;
		node_t   head_node;
		logic    head_valid;
	} rsp_t;

endpackage

// ----- design/llq_req_if.sv -----
interface llq_req_if;
	import llq_pkg::*;

	logic   valid;
	logic   ready;
	logic   func;
	queue_t queue_id;
	node_t  node_index;

	modport source (output valid, output func, output queue_id, output node_index,
		input ready);
	modport sink (input valid, input func, input queue_id, input node_index,
		output ready);
endinterface

// ----- design/llq_rsp_if.sv -----
interface llq_rsp_if;
	import llq_pkg::*;

	logic          valid;
	logic          ready;
	logic    [1:0] status;
	count_t        count;
	node_t         head_node;
	logic          head_valid;

	modport source (output valid, output status, output count, output head_node,
		output head_valid, input ready);
	modport sink (input valid, input status, input count, input head_node,
		input head_valid, output ready);
endinterface

// ----- design/llq_state.sv -----
module llq_state (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         commit,
	input  llq_pkg::req_t req,
	output llq_pkg::rsp_t rsp
);
	import llq_pkg::*;

	// Ring links, owner tags, heads and tails are only read for queued nodes or
	// nonempty queues, so they carry no reset.
	node_t  next_q  [NODES];
	node_t  prev_q  [NODES];
	queue_t owner_q [NODES];
	node_t  head_q  [QUEUES];
	node_t  tail_q  [QUEUES];
	logic   [NODES-1:0] inq_q;
	count_t count_q [QUEUES];

	queue_t q;
	node_t  n;
	count_t cnt;
	node_t  h;
	node_t  t;
	node_t  p;
	node_t  s;
	logic   member;
	logic   do_append;
	logic   do_remove;

	assign q      = req.queue_id;
	assign n      = req.node_index;
	assign cnt    = count_q[q];
	assign h      = head_q[q];
	assign t      = tail_q[q];
	assign p      = prev_q[n];
	assign s      = next_q[n];
	assign member = inq_q[n] && (owner_q[n] == q);

	always_comb begin
		do_append      = 1'b0;
		do_remove      = 1'b0;
		rsp.status     = ST_OK;
		rsp.count      = cnt;
		rsp.head_node  = h;
		rsp.head_valid = (cnt != '0);
		unique case (req.func)
			FUNC_APPEND: begin
				if (inq_q[n]) begin
					rsp.status = ST_ALREADY_QUEUED;
				end else begin
					do_append      = 1'b1;
					rsp.count      = cnt + count_t'(1);
					rsp.head_node  = (cnt == '0) ? n : h;
					rsp.head_valid = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (cnt == '0) begin
					rsp.status = ST_QUEUE_EMPTY;
				end else if (!member) begin
					rsp.status = ST_NOT_IN_QUEUE;
				end else begin
					do_remove      = 1'b1;
					rsp.count      = cnt - count_t'(1);
					rsp.head_node  = (h == n) ? s : h;
					rsp.head_valid = (cnt != count_t'(1));
				end
			end
			default: begin
				rsp.status = ST_OK;
			end
		endcase
		if (!rsp.head_valid) begin
			rsp.head_node = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && do_append) begin
			owner_q[n] <= q;
			tail_q[q]  <= n;
			if (cnt == '0) begin
				head_q[q] <= n;
				next_q[n] <= n;
				prev_q[n] <= n;
			end else begin
				next_q[t] <= n;
				prev_q[n] <= t;
				next_q[n] <= h;
				prev_q[h] <= n;
			end
		end
		if (commit && do_remove) begin
			next_q[p] <= s;
			prev_q[s] <= p;
			if (h == n) begin
				head_q[q] <= s;
			end
			if (t == n) begin
				tail_q[q] <= p;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inq_q <= '0;
			for (int i = 0; i < QUEUES; i++) begin
				count_q[i] <= '0;
			end
		end else if (commit) begin
			if (do_append) begin
				inq_q[n]   <= 1'b1;
				count_q[q] <= cnt + count_t'(1);
			end else if (do_remove) begin
				inq_q[n]   <= 1'b0;
				count_q[q] <= cnt - count_t'(1);
			end
		end
	end

endmodule

// ----- design/linked_list_queue_manager.sv -----
// Flow: an accepted request waits in the input register, is evaluated and committed as it
// moves into the result register, and its result transaction completes from there.
// Throughput: one request per cycle while the result channel keeps up; the state tables
// are updated at the edge where the request leaves the input register, so every request sees its forerunner.
// Reset: asynchronous and active low; it clears the membership bits, the queue counts and
// both pipeline valid flags. Link, owner, head and tail tables stay undefined until written.
module linked_list_queue_manager (
	input  logic         clk,
	input  logic         arst_n,
	llq_req_if.sink      req,
	llq_rsp_if.source    rsp
);
	import llq_pkg::*;

	// The input register holds one request transaction. It is evaluated against
	// the state tables by a single pass of logic, and the answer lands in the
	// result register at the same edge that commits the table update.
	logic  valid_s1;
	req_t  req_s1;
	logic  valid_s2;
	rsp_t  rsp_s2;
	rsp_t  rsp_comb;
	logic  advance;

	// The request in the input register may move on when the result register is
	// empty or its transaction completes in this cycle. The input register in
	// turn takes a new request whenever it is empty or moves on, so a waiting
	// result holds off new requests only once the input register is occupied too.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= '{func: func_t'(req.func), queue_id: req.queue_id,
				node_index: req.node_index};
		end
		if (advance) begin
			rsp_s2 <= rsp_comb;
		end
	end

	// The state block both answers the request and, when it commits, applies
	// the link, membership and count changes.
	llq_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.req    (req_s1),
		.rsp    (rsp_comb)
	);

	assign rsp.valid      = valid_s2;
	assign rsp.status     = rsp_s2.status;
	assign rsp.count      = rsp_s2.count;
	assign rsp.head_node  = rsp_s2.head_node;
	assign rsp.head_valid = rsp_s2.head_valid;

`ifndef ASSERT_OFF
	// A request that leaves the input register must show up as a result.
	a_advance_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp.valid)
		else $error("request left the input register without a result");

	// The head flag must agree with the reported element count.
	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.head_valid == (rsp.count != '0)))
		else $error("head_valid disagrees with count");

	// No queue can hold more nodes than the pool has.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.count <= count_t'(NODES)))
		else $error("queue count exceeds the node pool");

	// An empty queue failure reports an empty queue.
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_QUEUE_EMPTY)) |->
		((rsp.count == '0) && !rsp.head_valid))
		else $error("empty queue status with a nonempty queue");
`endif

endmodule

// ----- test/linked_list_queue_manager_test.sv -----
`timescale 1ns / 100ps

// Self-checking testbench for the linked list queue manager.
//
// Requests go in on the request channel and every accepted transaction is run
// straight away through a behavioural copy of the queue tables held here. That
// copy yields the reply the block must give, which is pushed onto a list of
// replies still due. A separate process pops that list for every reply
// transaction on the output channel and compares it field by field.
//
// The test tasks run in turn from one initial block. They cover:
// - a short list of hand-picked requests;
// - one queue filled with every node and then emptied again;
// - three phases of random traffic with different idling on each side;
// - a long output stall while the sender keeps offering requests.
module linked_list_queue_manager_test;
	import llq_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	// The output stall is long enough to back the whole pipeline up.
	localparam int HOLD_CYCLES  = 80;
	// A reply passes through the input register and then the result register after its request is accepted.
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;

	llq_req_if req_ch ();
	llq_rsp_if rsp_ch ();

	linked_list_queue_manager i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Behavioural copy of the queue tables. The link, owner and head entries are
	// only read for nodes that are queued or for queues that are not empty.
	bit [NODE_W-1:0]  succ_link [NODES];
	bit [NODE_W-1:0]  pred_link [NODES];
	bit               linked    [NODES];
	bit [QUEUE_W-1:0] owner_of  [NODES];
	bit [NODE_W-1:0]  head_of   [QUEUES];
	bit [COUNT_W-1:0] len_of    [QUEUES];

	rsp_t due_replies [$];

	int send_idle_pct;
	int rsp_idle_pct;
	event hold_start;
	logic rsp_holding;

	int cycle_count = 0;
	int mismatches = 0;
	int requests_sent;
	int replies_checked = 0;
	int status_hits [4] = '{default: 0};
	int deepest_queue;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one request to the copy of the tables and returns the reply the
	// block must give for it. A failed request leaves the tables untouched and
	// reports the addressed queue as it stands.
	function automatic rsp_t apply_request(req_t r);
		queue_t q;
		node_t n;
		node_t p;
		node_t s;
		node_t h;
		node_t t;
		rsp_t o;
		q = r.queue_id;
		n = r.node_index;
		o = '0;
		o.status = ST_OK;
		if (r.func == FUNC_APPEND) begin
			if (linked[n]) begin
				o.status = ST_ALREADY_QUEUED;
			end else begin
				if (len_of[q] == 0) begin
					head_of[q] = n;
					succ_link[n] = n;
					pred_link[n] = n;
				end else begin
					// The tail is the predecessor of the head, as the ring is closed.
					h = head_of[q];
					t = pred_link[h];
					succ_link[t] = n;
					pred_link[n] = t;
					succ_link[n] = h;
					pred_link[h] = n;
				end
				linked[n] = 1'b1;
				owner_of[n] = q;
				len_of[q] = len_of[q] + 1'b1;
			end
		end else if (len_of[q] == 0) begin
			// An empty queue is reported before membership is looked at.
			o.status = ST_QUEUE_EMPTY;
		end else if (!linked[n] || owner_of[n] != q) begin
			o.status = ST_NOT_IN_QUEUE;
		end else begin
			p = pred_link[n];
			s = succ_link[n];
			if (head_of[q] == n) begin
				head_of[q] = s;
			end
			succ_link[p] = s;
			pred_link[s] = p;
			linked[n] = 1'b0;
			len_of[q] = len_of[q] - 1'b1;
			if (len_of[q] == 0) begin
				head_of[q] = '0;
			end
		end
		o.count = len_of[q];
		o.head_valid = (len_of[q] != 0);
		o.head_node = o.head_valid ? head_of[q] : '0;
		if (int'(len_of[q]) > deepest_queue) begin
			deepest_queue = int'(len_of[q]);
		end
		return o;
	endfunction

	function automatic req_t make_req(func_t f, int q, int n);
		req_t r;
		r.func = f;
		r.queue_id = queue_t'(q);
		r.node_index = node_t'(n);
		return r;
	endfunction

	// Random request. Most requests are meant to succeed: an append takes a free
	// node and a remove takes a node that the queue really holds. The rest are
	// wholly random and mostly fail in one of the three ways.
	function automatic req_t pick_request();
		req_t r;
		node_t pool [$];
		int roll;
		r.func = func_t'($urandom_range(1));
		r.queue_id = queue_t'($urandom_range(QUEUES - 1));
		r.node_index = node_t'($urandom_range(NODES - 1));
		roll = $urandom_range(99);
		if (roll < 12) begin
			return r;
		end
		if (roll < 58) begin
			r.func = FUNC_APPEND;
			for (int i = 0; i < NODES; i++) begin
				if (!linked[i]) begin
					pool.push_back(node_t'(i));
				end
			end
		end else begin
			r.func = FUNC_REMOVE;
			for (int i = 0; i < NODES; i++) begin
				if (linked[i] && owner_of[i] == r.queue_id) begin
					pool.push_back(node_t'(i));
				end
			end
		end
		if (pool.size() != 0) begin
			r.node_index = pool[$urandom_range(pool.size() - 1)];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Offers one request, after a random number of idle cycles, and holds it
	// until the block accepts it. The expected reply is worked out at the edge of
	// acceptance. Valid is left high, so that a following request can go out in
	// the very next cycle.
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= r.func;
		req_ch.queue_id <= r.queue_id;
		req_ch.node_index <= r.node_index;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		due_replies.push_back(apply_request(r));
		requests_sent++;
	endtask

	// The sender goes quiet until every reply that is due has come back. It
	// always waits at least one edge, so that valid is never lowered and raised
	// again in the same time step.
	task automatic wait_for_replies();
		req_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (due_replies.size() != 0);
	endtask

	// Hand-picked requests: both field extremes, both operations and each way a
	// request can fail. Queue and node numbers cannot fall out of range at these
	// widths, so the wrap-around cases do not arise.
	task automatic check_directed_cases();
		send_idle_pct = 35;
		rsp_idle_pct = 76;
		send_request(make_req(FUNC_REMOVE, 0, 0));   // remove from an empty queue
		send_request(make_req(FUNC_APPEND, 0, 0));   // first node becomes the head
		send_request(make_req(FUNC_APPEND, 0, 15));
		send_request(make_req(FUNC_APPEND, 3, 15));  // node is already in queue 0
		send_request(make_req(FUNC_REMOVE, 3, 15));  // empty wins over membership
		send_request(make_req(FUNC_APPEND, 3, 7));
		send_request(make_req(FUNC_REMOVE, 3, 0));   // node belongs to another queue
		send_request(make_req(FUNC_REMOVE, 3, 5));   // node is not queued at all
		send_request(make_req(FUNC_APPEND, 0, 5));
		send_request(make_req(FUNC_REMOVE, 0, 15));  // unlink from the middle
		send_request(make_req(FUNC_REMOVE, 0, 0));   // head moves to its successor
		send_request(make_req(FUNC_REMOVE, 0, 0));   // the node is gone already
		send_request(make_req(FUNC_REMOVE, 0, 5));   // queue becomes empty again
		send_request(make_req(FUNC_APPEND, 3, 7));   // re-append of a queued node
		send_request(make_req(FUNC_REMOVE, 3, 7));
		wait_for_replies();
	endtask

	// Frees every node, then appends all of them to one queue in a shuffled
	// order, which takes the count to its maximum, and removes them again in a
	// different order.
	task automatic check_full_queue();
		node_t order [NODES];
		node_t swap;
		int j;
		send_idle_pct = 76;
		rsp_idle_pct = 35;
		for (int i = 0; i < NODES; i++) begin
			if (linked[i]) begin
				send_request(make_req(FUNC_REMOVE, owner_of[i], i));
			end
			order[i] = node_t'(i);
		end
		for (int pass = 0; pass < 2; pass++) begin
			for (int i = NODES - 1; i > 0; i--) begin
				j = $urandom_range(i);
				swap = order[i];
				order[i] = order[j];
				order[j] = swap;
			end
			for (int i = 0; i < NODES; i++) begin
				send_request(make_req(pass == 0 ? FUNC_APPEND : FUNC_REMOVE, 1, order[i]));
			end
		end
		wait_for_replies();
	endtask

	// One phase of random traffic. Every hundred requests the sender pauses
	// until all replies have been checked.
	task automatic check_random_traffic(input int send_pct, input int rsp_pct, input int items);
		send_idle_pct = send_pct;
		rsp_idle_pct = rsp_pct;
		for (int i = 0; i < items; i++) begin
			send_request(pick_request());
			if (i % 100 == 99) begin
				wait_for_replies();
			end
		end
		wait_for_replies();
	endtask

	// The receiver refuses replies for a long stretch while the sender offers a
	// request every cycle, so the block fills up and has to stall its input.
	task automatic check_output_stall();
		send_idle_pct = 0;
		rsp_idle_pct = 0;
		-> hold_start;
		for (int i = 0; i < 40; i++) begin
			send_request(pick_request());
		end
		wait_for_replies();
	endtask

	// Counts out the long output stall on request from a test task.
	initial begin
		rsp_holding = 1'b0;
		forever begin
			@(hold_start);
			rsp_holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rsp_holding <= 1'b0;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !rsp_holding && ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// Every reply transaction is matched against the oldest reply that is due.
	always @(posedge clk) begin : reply_check
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_replies.size() == 0) begin
				report_mismatch("reply transaction with no request outstanding");
			end else begin
				want = due_replies.pop_front();
				replies_checked++;
				status_hits[want.status]++;
				if (rsp_ch.status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %s",
						rsp_ch.status, want.status.name()));
				end
				if (rsp_ch.count !== want.count) begin
					report_mismatch($sformatf("count %0d, expected %0d",
						rsp_ch.count, want.count));
				end
				if (rsp_ch.head_node !== want.head_node) begin
					report_mismatch($sformatf("head_node %0d, expected %0d",
						rsp_ch.head_node, want.head_node));
				end
				if (rsp_ch.head_valid !== want.head_valid) begin
					report_mismatch($sformatf("head_valid %0b, expected %0b",
						rsp_ch.head_valid, want.head_valid));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timed out with %0d replies outstanding", due_replies.size());
			$display("FAIL linked_list_queue_manager");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_APPEND;
		req_ch.queue_id = '0;
		req_ch.node_index = '0;
		send_idle_pct = 0;
		rsp_idle_pct = 0;
		requests_sent = 0;
		deepest_queue = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_directed_cases();
		check_full_queue();
		check_random_traffic(35, 76, 230);
		check_random_traffic(76, 35, 230);
		check_random_traffic(0, 0, 200);
		check_output_stall();

		// Allow any stray reply to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d requests sent and %0d replies checked, deepest queue %0d",
			requests_sent, replies_checked, deepest_queue);
		$display("replies by status: ok %0d, already queued %0d, empty %0d, not in queue %0d",
			status_hits[ST_OK], status_hits[ST_ALREADY_QUEUED],
			status_hits[ST_QUEUE_EMPTY], status_hits[ST_NOT_IN_QUEUE]);
		if (mismatches == 0 && due_replies.size() == 0) begin
			$display("PASS linked_list_queue_manager");
		end else begin
			$display("FAIL linked_list_queue_manager");
		end
		$finish;
	end

endmodule
